// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with reset disable; expects clk and rst_n in scope.
`define RRFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never hold at a clock edge outside reset.
`define RRFP_NEVER(label, cond, msg) \
    `RRFP_ASSERT(label, !(cond), msg)

`endif

// ===== hw/rtl/rrfp_pkg.sv =====
`default_nettype none

package rrfp_pkg;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_TAIL  = 2'd1;
    localparam logic [1:0] ST_NO_MARKER = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [7:0]  MARKER_BYTE   = 8'hAA;
    localparam logic [15:0] MARKER_MARGIN = 16'd10;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd10;
    localparam logic [3:0]  CAPTURE_BYTES = 4'd9;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        present;
        logic [7:0]  tgt_state;
        logic [15:0] move_dist;
        logic [7:0]  move_energy;
        logic [15:0] still_dist;
        logic [7:0]  still_energy;
        logic [15:0] detect_dist;
    } report_t;

    function automatic logic [7:0] head_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hF4;
            2'd1:    b = 8'hF3;
            2'd2:    b = 8'hF2;
            default: b = 8'hF1;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hF8;
            2'd1:    b = 8'hF7;
            2'd2:    b = 8'hF6;
            default: b = 8'hF5;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rrfp_if.sv =====
`default_nettype none

interface rrfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrfp_report_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        present;
    logic [7:0]  tgt_state;
    logic [15:0] move_dist;
    logic [7:0]  move_energy;
    logic [15:0] still_dist;
    logic [7:0]  still_energy;
    logic [15:0] detect_dist;

    modport source (
        output valid, output status, output present, output tgt_state,
        output move_dist, output move_energy, output still_dist,
        output still_energy, output detect_dist, input ready
    );
    modport sink (
        input valid, input status, input present, input tgt_state,
        input move_dist, input move_energy, input still_dist,
        input still_energy, input detect_dist, output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/rrfp_in_stage.sv =====
`default_nettype none

module rrfp_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rrfp_byte_if.sink          rx,
    input  wire logic          step,
    output rrfp_pkg::beat_t    beat
);
    import rrfp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       take;

    // stage frees up in the same cycle its byte is consumed
    assign rx.ready   = !valid_reg || step;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take || (valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rrfp_parser.sv =====
`default_nettype none

`include "assert_macros.svh"

module rrfp_parser #(
    parameter int unsigned BUFFER_BYTES = 512
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rrfp_pkg::beat_t beat,
    input  wire logic          out_free,
    output logic               step,
    output logic               emit,
    output rrfp_pkg::report_t  result
);
    import rrfp_pkg::*;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_LO  = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_TAIL    = 3'd4;

    localparam logic [16:0] BUF_LIMIT = 17'(BUFFER_BYTES);

    logic [2:0]  phase_reg,    phase_next;
    logic [1:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic [15:0] len_reg,      len_next;
    logic [15:0] pos_reg,      pos_next;
    logic        marker_reg,   marker_next;
    logic [3:0]  cap_cnt_reg,  cap_cnt_next;
    logic        tail_bad_reg, tail_bad_next;
    logic [71:0] cap_reg;
    logic        cap_we;

    logic [7:0]  b;
    logic [15:0] full_len;
    logic [15:0] pos_inc;
    logic        too_long;
    logic        bad_now;
    logic [1:0]  st;

    assign b        = beat.data;
    assign full_len = {b, len_reg[7:0]};
    assign too_long = ({1'b0, full_len} + FRAME_OVERHEAD) > BUF_LIMIT;
    assign pos_inc  = pos_reg + 16'd1;
    assign bad_now  = tail_bad_reg || (b != tail_byte(pos_reg[1:0]));

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        marker_next   = marker_reg;
        cap_cnt_next  = cap_cnt_reg;
        tail_bad_next = tail_bad_reg;
        cap_we        = 1'b0;
        emit          = 1'b0;
        st            = ST_OK;
        case (phase_reg)
            PH_HUNT:
            begin
                if (b == head_byte(hdr_cnt_reg))
                begin
                    if (hdr_cnt_reg == 2'd3)
                    begin
                        hdr_cnt_next = 2'd0;
                        phase_next   = PH_LEN_LO;
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    end
                end
                else
                begin
                    hdr_cnt_next = (b == head_byte(2'd0)) ? 2'd1 : 2'd0;
                end
            end
            PH_LEN_LO:
            begin
                len_next   = {8'h00, b};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next      = full_len;
                pos_next      = 16'd0;
                marker_next   = 1'b0;
                cap_cnt_next  = 4'd0;
                tail_bad_next = 1'b0;
                if (too_long)
                begin
                    emit         = 1'b1;
                    st           = ST_TOO_LONG;
                    phase_next   = PH_HUNT;
                    hdr_cnt_next = 2'd0;
                end
                else
                begin
                    phase_next = (full_len == 16'd0) ? PH_TAIL : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (!marker_reg)
                begin
                    if (len_reg > MARKER_MARGIN && pos_reg < (len_reg - MARKER_MARGIN)
                        && b == MARKER_BYTE)
                    begin
                        marker_next  = 1'b1;
                        cap_cnt_next = 4'd0;
                    end
                end
                else if (cap_cnt_reg < CAPTURE_BYTES)
                begin
                    cap_we       = 1'b1;
                    cap_cnt_next = cap_cnt_reg + 4'd1;
                end
                if (pos_inc >= len_reg)
                begin
                    pos_next   = 16'd0;
                    phase_next = PH_TAIL;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            PH_TAIL:
            begin
                tail_bad_next = bad_now;
                if (pos_reg[1:0] == 2'd3)
                begin
                    emit         = 1'b1;
                    pos_next     = 16'd0;
                    phase_next   = PH_HUNT;
                    hdr_cnt_next = 2'd0;
                    if (bad_now)
                    begin
                        st = ST_BAD_TAIL;
                    end
                    else if (!marker_reg || cap_cnt_reg < CAPTURE_BYTES)
                    begin
                        st = ST_NO_MARKER;
                    end
                    else
                    begin
                        st = ST_OK;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            default:
            begin
                phase_next   = PH_HUNT;
                hdr_cnt_next = 2'd0;
            end
        endcase
    end

    // a frame end waits only if the result register is still held
    assign step = beat.valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            hdr_cnt_reg  <= 2'd0;
            len_reg      <= 16'd0;
            pos_reg      <= 16'd0;
            marker_reg   <= 1'b0;
            cap_cnt_reg  <= 4'd0;
            tail_bad_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            marker_reg   <= marker_next;
            cap_cnt_reg  <= cap_cnt_next;
            tail_bad_reg <= tail_bad_next;
        end
    end

    // every byte is written once per frame before an ok result reads it
    always_ff @(posedge clk)
    begin
        if (step && cap_we)
        begin
            cap_reg[8*cap_cnt_reg +: 8] <= b;
        end
    end

    always_comb
    begin
        result.status       = st;
        result.present      = 1'b0;
        result.tgt_state    = 8'h00;
        result.move_dist    = 16'h0000;
        result.move_energy  = 8'h00;
        result.still_dist   = 16'h0000;
        result.still_energy = 8'h00;
        result.detect_dist  = 16'h0000;
        if (st == ST_OK)
        begin
            result.present      = (cap_reg[7:0] != 8'h00);
            result.tgt_state    = cap_reg[7:0];
            result.move_dist    = cap_reg[23:8];
            result.move_energy  = cap_reg[31:24];
            result.still_dist   = cap_reg[47:32];
            result.still_energy = cap_reg[55:48];
            result.detect_dist  = cap_reg[71:56];
        end
    end

    `RRFP_NEVER(a_cap_cnt_range, cap_cnt_reg > CAPTURE_BYTES, "capture count past nine")
    `RRFP_NEVER(a_cap_without_marker, !marker_reg && cap_cnt_reg != 4'd0,
        "bytes captured before marker")
    `RRFP_ASSERT(a_emit_to_hunt, step && emit |=> phase_reg == PH_HUNT && hdr_cnt_reg == 2'd0,
        "result not followed by header hunt")
    `RRFP_NEVER(a_tail_pos, phase_reg == PH_TAIL && pos_reg > 16'd3, "tail position past four")

endmodule

`default_nettype wire

// ===== hw/rtl/rrfp_out_reg.sv =====
`default_nettype none

module rrfp_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire rrfp_pkg::report_t result,
    output logic               out_free,
    rrfp_report_if.source      report
);
    import rrfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    report_t data_reg;

    assign out_free   = !valid_reg || report.ready;
    assign valid_next = load || (valid_reg && !report.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign report.valid        = valid_reg;
    assign report.status       = data_reg.status;
    assign report.present      = data_reg.present;
    assign report.tgt_state    = data_reg.tgt_state;
    assign report.move_dist    = data_reg.move_dist;
    assign report.move_energy  = data_reg.move_energy;
    assign report.still_dist   = data_reg.still_dist;
    assign report.still_energy = data_reg.still_energy;
    assign report.detect_dist  = data_reg.detect_dist;

endmodule

`default_nettype wire

// ===== hw/rtl/radar_report_frame_parser_core.sv =====
// Radar report frame parser: takes one serial byte per beat on rx, hunts the
// F4 F3 F2 F1 header, reads a little-endian 16-bit length, captures the nine
// bytes after the first 0xAA marker that lies below length-10 in the payload,
// checks the F8 F7 F6 F5 tail and sends one report beat per frame (status 0 ok,
// 1 bad tail, 2 no marker, 3 frame larger than BUFFER_BYTES, reported right
// after the length). Bytes of a rejected frame are not rescanned. Throughput is
// one byte per cycle save for stalls: a byte lands in an input register, the
// parse step acts on it there, and reports go to a one-entry output register.
// A report is formed from the last frame byte in the input register and goes to
// the output register. Bytes stall only when a frame end meets a held report.
`default_nettype none

module radar_report_frame_parser_core #(
    parameter int unsigned BUFFER_BYTES = 512
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    rrfp_byte_if.sink      rx,
    rrfp_report_if.source  report
);
    import rrfp_pkg::*;

    beat_t   beat;
    report_t result;
    logic    step;
    logic    emit;
    logic    out_free;

    rrfp_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .step  (step),
        .beat  (beat)
    );

    rrfp_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (beat),
        .out_free (out_free),
        .step     (step),
        .emit     (emit),
        .result   (result)
    );

    rrfp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && emit),
        .result   (result),
        .out_free (out_free),
        .report   (report)
    );

endmodule

`default_nettype wire
